### rtl/ps2_mouse_packet_decoder_defines.svh
// Assertion macros used by the PS/2 mouse decoder checker.
`ifndef PS2_MOUSE_PACKET_DECODER_DEFINES_SVH
`define PS2_MOUSE_PACKET_DECODER_DEFINES_SVH

// Implication checked every edge outside reset.
`define PSMD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked every edge outside reset.
`define PSMD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Implication checked at every edge, reset included.
`define PSMD_ASSERT_ALL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error(msg);

`endif

### rtl/psmd_pkg.sv
// Types and constants for the PS/2 mouse packet decoder.
`timescale 1ns / 1ps
package psmd_pkg;

  localparam int AUX_BIT     = 5;
  localparam int QUEUE_DEPTH = 2;
  localparam int OUT_DEPTH   = 2;
  localparam int NUM_BUTTONS = 3;

  typedef enum logic [1:0] {
    EV_MOVE    = 2'd0,
    EV_PRESS   = 2'd1,
    EV_RELEASE = 2'd2
  } event_kind_t;

  typedef struct packed {
    logic [7:0] status_byte;
    logic [7:0] data_byte;
  } in_word_t;

  typedef struct packed {
    event_kind_t       event_kind;
    logic signed [7:0] move_x;
    logic signed [7:0] move_y;
    logic [1:0]        button_number;
    logic              last_event;
  } out_word_t;

  // One complete packet: bit 0 of mask is the move event, bits 1..3 the buttons.
  typedef struct packed {
    logic [NUM_BUTTONS:0]   mask;
    logic [NUM_BUTTONS-1:0] pressed;
    logic [7:0]             dx;
    logic [7:0]             dy;
  } job_t;

endpackage

### rtl/ps2_mouse_packet_decoder.sv
// Top level of the PS/2 mouse three-byte packet decoder.
// Usage:
//   Input queue: drive in_word (status and data byte read from the controller)
//   with in_push; a word is taken at an edge where in_push is high and in_full
//   low. Words whose status lacks the aux data bit are dropped.
//   Result queue: while out_empty is low the oldest event is on out_word;
//   raise out_pop to take it. last_event marks a packet's final event.
//   Config: cfg_wr_en with cfg_wr_data sets enabled_r (reset value 1);
//   write it only while no packet is in flight.
// Timing:
//   Input words are taken one per cycle while in_full is low; a packet's
//   first event passes the job queue, expander registers and result queue,
//   further events follow one per cycle while the result queue has room.
//   A packet gives up to four events, so the expander sets the sustained
//   rate; a quiet or disabled packet gives no events, costs it no time.
// Reset: synchronous rst_n clears byte position, stored buttons and both
//   queues. When the receiver stalls, the result queue fills, then the job
//   queue, and in_full rises.
`timescale 1ns / 1ps
module ps2_mouse_packet_decoder #(
  parameter int QUEUE_DEPTH = psmd_pkg::QUEUE_DEPTH,
  parameter int OUT_DEPTH   = psmd_pkg::OUT_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  input  psmd_pkg::in_word_t  in_word,
  output logic                in_full,
  input  logic                out_pop,
  output psmd_pkg::out_word_t out_word,
  output logic                out_empty,
  input  logic                cfg_wr_en,
  input  logic                cfg_wr_data
);

  logic                job_push_w, job_full_w, job_pop_w, job_empty_w;
  psmd_pkg::job_t      job_in_w, job_out_w;
  logic                ev_push_w, ev_full_w;
  psmd_pkg::out_word_t ev_word_w;

  psmd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_push     (in_push),
    .in_word     (in_word),
    .in_full     (in_full),
    .job_push    (job_push_w),
    .job_word    (job_in_w),
    .job_full    (job_full_w)
  );

  psmd_fifo #(.T(psmd_pkg::job_t), .DEPTH(QUEUE_DEPTH)) u_job_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (job_push_w),
    .wdata (job_in_w),
    .full  (job_full_w),
    .pop   (job_pop_w),
    .rdata (job_out_w),
    .empty (job_empty_w)
  );

  psmd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_empty (job_empty_w),
    .job_word  (job_out_w),
    .job_pop   (job_pop_w),
    .out_full  (ev_full_w),
    .out_push  (ev_push_w),
    .out_word  (ev_word_w)
  );

  psmd_fifo #(.T(psmd_pkg::out_word_t), .DEPTH(OUT_DEPTH)) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (ev_push_w),
    .wdata (ev_word_w),
    .full  (ev_full_w),
    .pop   (out_pop),
    .rdata (out_word),
    .empty (out_empty)
  );

endmodule

### rtl/psmd_fifo.sv
// Small register queue used between the decoder stages and at the output.
`timescale 1ns / 1ps
module psmd_fifo #(
  parameter type T     = logic,
  parameter int  DEPTH = 2
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  T     wdata,
  output logic full,
  input  logic pop,
  output T     rdata,
  output logic empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  T              mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_wr, do_rd;

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);
  assign do_wr = push && !full;
  assign do_rd = pop && !empty;
  assign rdata = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

### rtl/psmd_front.sv
// Front stage: collects packet bytes, tracks buttons and queues event jobs.
`timescale 1ns / 1ps
module psmd_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic               cfg_wr_data,
  input  logic               in_push,
  input  psmd_pkg::in_word_t in_word,
  output logic               in_full,
  output logic               job_push,
  output psmd_pkg::job_t     job_word,
  input  logic               job_full
);

  logic                               enabled_r;
  logic [1:0]                         pos_r, pos_nxt;
  logic [7:0]                         b0_r, b0_nxt;
  logic [7:0]                         b1_r, b1_nxt;
  logic [psmd_pkg::NUM_BUTTONS-1:0]   btn_r, btn_nxt;
  logic                               accept, aux, last_byte;
  logic                               move;
  logic [psmd_pkg::NUM_BUTTONS-1:0]   changed;

  assign in_full   = job_full;
  assign accept    = in_push && !job_full;
  assign aux       = in_word.status_byte[psmd_pkg::AUX_BIT];
  assign last_byte = pos_r[1];

  // dy is the negated data byte; it is zero exactly when the data byte is zero
  assign move    = (b1_r != 8'd0) || (in_word.data_byte != 8'd0);
  assign changed = b0_r[psmd_pkg::NUM_BUTTONS-1:0] ^ btn_r;

  assign job_word.mask    = {changed, move};
  assign job_word.pressed = b0_r[psmd_pkg::NUM_BUTTONS-1:0];
  assign job_word.dx      = b1_r;
  assign job_word.dy      = 8'd0 - in_word.data_byte;
  assign job_push = accept && aux && last_byte && enabled_r && (job_word.mask != '0);

  always_comb begin
    pos_nxt = pos_r;
    b0_nxt  = b0_r;
    b1_nxt  = b1_r;
    btn_nxt = btn_r;
    if (accept && aux) begin
      if (!last_byte) begin
        if (pos_r[0]) begin
          b1_nxt = in_word.data_byte;
        end else begin
          b0_nxt = in_word.data_byte;
        end
        pos_nxt = pos_r + 2'd1;
      end else begin
        pos_nxt = 2'd0;
        if (enabled_r) begin
          btn_nxt = b0_r[psmd_pkg::NUM_BUTTONS-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r <= 1'b1;
      pos_r     <= 2'd0;
      b0_r      <= 8'd0;
      b1_r      <= 8'd0;
      btn_r     <= '0;
    end else begin
      if (cfg_wr_en) begin
        enabled_r <= cfg_wr_data;
      end
      pos_r <= pos_nxt;
      b0_r  <= b0_nxt;
      b1_r  <= b1_nxt;
      btn_r <= btn_nxt;
    end
  end

endmodule

### rtl/psmd_back.sv
// Back stage: expands one packet job into its events, one per cycle while out_full is low.
`timescale 1ns / 1ps
module psmd_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                job_empty,
  input  psmd_pkg::job_t      job_word,
  output logic                job_pop,
  input  logic                out_full,
  output logic                out_push,
  output psmd_pkg::out_word_t out_word
);

  localparam int MW = psmd_pkg::NUM_BUTTONS + 1;

  logic                             busy_r, busy_nxt;
  logic [MW-1:0]                    mask_r, mask_nxt;
  logic [psmd_pkg::NUM_BUTTONS-1:0] pressed_r, pressed_nxt;
  logic [7:0]                       dx_r, dx_nxt;
  logic [7:0]                       dy_r, dy_nxt;
  logic [MW-1:0]                    lowest, mask_rest;
  logic                             emit, last;

  assign lowest    = mask_r & (~mask_r + 1'b1);
  assign mask_rest = mask_r & ~lowest;
  assign last      = (mask_rest == '0);
  assign emit      = busy_r && !out_full;
  assign out_push  = emit;
  assign job_pop   = !job_empty && (!busy_r || (emit && last));

  always_comb begin
    out_word               = '0;
    out_word.last_event    = last;
    case (lowest)
      4'b0010: begin
        out_word.event_kind    = pressed_r[0] ? psmd_pkg::EV_PRESS : psmd_pkg::EV_RELEASE;
        out_word.button_number = 2'd1;
      end
      4'b0100: begin
        out_word.event_kind    = pressed_r[1] ? psmd_pkg::EV_PRESS : psmd_pkg::EV_RELEASE;
        out_word.button_number = 2'd2;
      end
      4'b1000: begin
        out_word.event_kind    = pressed_r[2] ? psmd_pkg::EV_PRESS : psmd_pkg::EV_RELEASE;
        out_word.button_number = 2'd3;
      end
      default: begin
        out_word.event_kind = psmd_pkg::EV_MOVE;
        out_word.move_x     = dx_r;
        out_word.move_y     = dy_r;
      end
    endcase
  end

  always_comb begin
    busy_nxt    = busy_r;
    mask_nxt    = mask_r;
    pressed_nxt = pressed_r;
    dx_nxt      = dx_r;
    dy_nxt      = dy_r;
    if (job_pop) begin
      busy_nxt    = 1'b1;
      mask_nxt    = job_word.mask;
      pressed_nxt = job_word.pressed;
      dx_nxt      = job_word.dx;
      dy_nxt      = job_word.dy;
    end else if (emit) begin
      mask_nxt = mask_rest;
      busy_nxt = !last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      mask_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      mask_r <= mask_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pressed_r <= pressed_nxt;
    dx_r      <= dx_nxt;
    dy_r      <= dy_nxt;
  end

endmodule

### rtl/psmd_checker.sv
// Port-level checker for the PS/2 mouse packet decoder, bound to the top level.
`timescale 1ns / 1ps
`include "ps2_mouse_packet_decoder_defines.svh"
module psmd_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_full,
  input logic                out_pop,
  input logic                out_empty,
  input psmd_pkg::out_word_t out_word
);

  // queues come out of reset empty
  `PSMD_ASSERT_ALL(a_empty_after_reset, $past(rst_n) == 1'b0, out_empty && !in_full, "queues not empty after reset")

  // a waiting word holds until it is popped
  `PSMD_ASSERT_NXT(a_head_stable, !out_empty && !out_pop, !out_empty && $stable(out_word), "result word changed while stalled")

  // move events carry motion and no button
  `PSMD_ASSERT_IMP(a_move_shape, !out_empty && out_word.event_kind == psmd_pkg::EV_MOVE, out_word.button_number == 2'd0 && (out_word.move_x != 8'sd0 || out_word.move_y != 8'sd0), "bad move event")

  // button events carry a button and no motion
  `PSMD_ASSERT_IMP(a_button_shape, !out_empty && out_word.event_kind != psmd_pkg::EV_MOVE, out_word.button_number != 2'd0 && out_word.move_x == 8'sd0 && out_word.move_y == 8'sd0, "bad button event")

endmodule

bind ps2_mouse_packet_decoder psmd_checker u_psmd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_full   (in_full),
  .out_pop   (out_pop),
  .out_empty (out_empty),
  .out_word  (out_word)
);
